FILE: hdl/dpa_pkg.sv
// ----------------------------------------------------------------------------
// dpa_pkg
// Shared types and constants of the dynamic partition allocator.
// ----------------------------------------------------------------------------
package dpa_pkg;

    localparam int MAX_PARTS_DEF = 64;
    localparam int ADDR_W        = 16;
    localparam int LEN_W         = 17;
    localparam int ORD_W         = 16;
    localparam int STAMP_W       = 32;
    localparam int FAIL_W        = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 17;

    localparam logic [LEN_W-1:0] MEM_SIZE_MAX = LEN_W'(65536);
    localparam logic [LEN_W-1:0] MEM_SIZE_RST = LEN_W'(4096);
    localparam logic [LEN_W-1:0] MIN_SIZE_RST = LEN_W'(64);
    localparam logic [FAIL_W-1:0] FREQ_RST    = FAIL_W'(2);
    localparam logic [FAIL_W-1:0] FAIL_SAT    = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MEM_SIZE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PART     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VICTIM_MODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COMPACT_FREQ = 3'd4;

    // actions
    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_EVICT   = 2'd1;
    localparam logic [1:0] ACT_COMPACT = 2'd2;

    // result status
    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_TOO_BIG  = 2'd1;
    localparam logic [1:0] STS_NO_SPACE = 2'd2;
    localparam logic [1:0] STS_NO_BUSY  = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0]  start;
        logic [LEN_W-1:0]   len;
        logic               busy;
        logic [ORD_W-1:0]   order;
        logic [STAMP_W-1:0] stamp;
    } part_rec_t;

    typedef struct packed {
        logic accept;
        logic scan;
        logic decide;
        logic shift;
        logic split_wr;
        logic grant_wr;
        logic evict_wr;
        logic compact;
        logic tail_wr;
    } dpa_cmd_t;

    typedef struct packed {
        logic       loop_done;
        logic       shift_done;
        logic [1:0] action;
        logic       too_big;
        logic       pick_v;
        logic       split;
        logic       fail_compact;
        logic       vic_v;
    } dpa_stat_t;

endpackage

FILE: hdl/dynamic_partition_allocator.sv
// ----------------------------------------------------------------------------
// dynamic_partition_allocator
// Variable partition allocator with first/best fit, FIFO/LRU eviction and
// compaction over an address-ordered partition table.
//
// Input stream: s_tuser carries the action (allocate, evict, compact),
// s_tdata the requested size. One result beat is produced for every input
// beat, in order, on the m_ stream.
// Configuration: a write on cfg_wr_en stores cfg_wdata into register
// cfg_index; write only while no beat is in flight. Writing mem_size
// reinitialises the table to one free partition.
// Flow: one beat at a time. The table scan reads every entry; an
// allocation that splits first shifts each entry above the chosen one up
// by one place, and a compaction rereads the whole table. The table
// memory, with one read and one write port, sets the pace. The next beat
// is taken as soon as the result is in the output register, so a stalled
// receiver holds one result and one beat in work.
// Reset: synchronous, active low; restores register defaults and an empty
// table, and needs no clearing pass.
// ----------------------------------------------------------------------------
module dynamic_partition_allocator
    import dpa_pkg::*;
#(
    parameter int MAX_PARTS = MAX_PARTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,  // req_size[16:0], zero pad
    input  logic [1:0]            s_tuser,  // action[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // status[1:0], alloc_start[17:2], alloc_order[33:18], evicted_valid[34],
    // evicted_start[50:35], compacted[51], zero pad
    output logic [55:0]           m_tdata
);

    dpa_cmd_t          cmd;
    dpa_stat_t         stat;
    logic              out_load, out_free;
    logic [1:0]        res_status;
    logic [ADDR_W-1:0] res_alloc_start, res_ev_start;
    logic [ORD_W-1:0]  res_alloc_order;
    logic              res_ev_valid, res_compacted;
    logic              m_tvalid_reg;
    logic [55:0]       m_tdata_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    dpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .out_load (out_load),
        .stat     (stat),
        .cmd      (cmd)
    );

    dpa_datapath #(
        .MAX_PARTS (MAX_PARTS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_action       (s_tuser),
        .in_req          (s_tdata[LEN_W-1:0]),
        .cmd             (cmd),
        .stat            (stat),
        .res_status      (res_status),
        .res_alloc_start (res_alloc_start),
        .res_alloc_order (res_alloc_order),
        .res_ev_valid    (res_ev_valid),
        .res_ev_start    (res_ev_start),
        .res_compacted   (res_compacted)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_tvalid_reg <= 1'b0;
        else if (out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (out_load)
            m_tdata_reg <= {4'b0, res_compacted, res_ev_start, res_ev_valid,
                            res_alloc_order, res_alloc_start, res_status};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: hdl/dpa_datapath.sv
// ----------------------------------------------------------------------------
// dpa_datapath
// Partition table memory, scan / shift / compaction engines and state regs.
// ----------------------------------------------------------------------------
module dpa_datapath
    import dpa_pkg::*;
#(
    parameter int MAX_PARTS = MAX_PARTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [1:0]            in_action,
    input  logic [LEN_W-1:0]      in_req,
    input  dpa_cmd_t              cmd,
    output dpa_stat_t             stat,
    output logic [1:0]            res_status,
    output logic [ADDR_W-1:0]     res_alloc_start,
    output logic [ORD_W-1:0]      res_alloc_order,
    output logic                  res_ev_valid,
    output logic [ADDR_W-1:0]     res_ev_start,
    output logic                  res_compacted
);

    localparam int IW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int CW = $clog2(MAX_PARTS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PARTS);

    part_rec_t mem [MAX_PARTS];

    // configuration
    logic [LEN_W-1:0]   mem_size_reg, min_size_reg;
    logic               fit_mode_reg, vic_mode_reg;
    logic [FAIL_W-1:0]  freq_reg;
    // control state
    logic [CW-1:0]      cnt_reg, idx_reg, sh_idx_reg, w_reg;
    logic               e0_ok_reg, chk_v_reg, pend_v_reg, pick_v_reg, vic_v_reg, split_reg;
    logic [ORD_W-1:0]   next_order_reg;
    logic [FAIL_W-1:0]  fail_reg;
    logic [STAMP_W-1:0] tick_reg;
    // payload
    logic [1:0]         action_reg;
    logic [LEN_W-1:0]   req_reg, need_reg, off_reg;
    logic [STAMP_W-1:0] now_reg, vic_age_reg;
    logic [IW-1:0]      chk_idx_reg, pend_addr_reg, pick_idx_reg, vic_idx_reg;
    part_rec_t          pick_rec_reg, vic_rec_reg, rd_q_reg;
    logic               rd_dflt_reg;

    part_rec_t          ent, wr_data;
    logic               wr_en;
    logic [IW-1:0]      wr_addr, rd_addr;
    logic [LEN_W-1:0]   min_eff, need_new, rem;
    logic [FAIL_W-1:0]  fail_inc;
    logic [STAMP_W-1:0] age;
    logic [CW-1:0]      pick_nxt;
    logic               sh_go, fit_hit, vic_hit, tail_ok;
    logic [LEN_W-1:0]   cfg_clamped;

    // entry 0 reads as the whole memory until first written
    always_comb begin
        if (rd_dflt_reg) begin
            ent       = '0;
            ent.len   = mem_size_reg;
        end else begin
            ent = rd_q_reg;
        end
    end

    assign min_eff  = (min_size_reg == '0) ? LEN_W'(1) : min_size_reg;
    assign need_new = (in_req < min_eff) ? min_eff : in_req;
    assign rem      = pick_rec_reg.len - need_reg;
    assign fail_inc = (fail_reg == FAIL_SAT) ? fail_reg : fail_reg + FAIL_W'(1);
    assign pick_nxt = CW'(pick_idx_reg) + CW'(1);
    assign sh_go    = sh_idx_reg > pick_nxt;
    assign tail_ok  = (off_reg < mem_size_reg) && (w_reg < MAX_CNT);
    assign age      = vic_mode_reg ? (tick_reg - ent.stamp)
                                   : {{(STAMP_W-ORD_W){1'b0}}, next_order_reg - ent.order};
    assign fit_hit  = !ent.busy && (ent.len >= need_reg) &&
                      (!pick_v_reg || (fit_mode_reg && ent.len < pick_rec_reg.len));
    assign vic_hit  = ent.busy && (!vic_v_reg || age > vic_age_reg);

    always_comb begin
        if (cfg_wdata == '0)
            cfg_clamped = LEN_W'(1);
        else if (cfg_wdata > MEM_SIZE_MAX)
            cfg_clamped = MEM_SIZE_MAX;
        else
            cfg_clamped = cfg_wdata;
    end

    always_comb begin
        stat.loop_done    = (idx_reg >= cnt_reg) && !chk_v_reg;
        stat.shift_done   = !sh_go && !pend_v_reg;
        stat.action       = action_reg;
        stat.too_big      = req_reg > mem_size_reg;
        stat.pick_v       = pick_v_reg;
        stat.split        = (rem != '0) && (cnt_reg < MAX_CNT);
        stat.fail_compact = fail_inc >= freq_reg;
        stat.vic_v        = vic_v_reg;
    end

    // read address
    always_comb begin
        if (cmd.shift)
            rd_addr = IW'(sh_idx_reg - CW'(1));
        else
            rd_addr = idx_reg[IW-1:0];
    end

    // write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = ent;
        if (cmd.shift && pend_v_reg) begin
            wr_en   = 1'b1;
            wr_addr = pend_addr_reg;
        end else if (cmd.compact && chk_v_reg && ent.busy) begin
            wr_en         = 1'b1;
            wr_addr       = w_reg[IW-1:0];
            wr_data.start = off_reg[ADDR_W-1:0];
        end else if (cmd.tail_wr && tail_ok) begin
            wr_en   = 1'b1;
            wr_addr = w_reg[IW-1:0];
            wr_data = '0;
            wr_data.start = off_reg[ADDR_W-1:0];
            wr_data.len   = mem_size_reg - off_reg;
        end else if (cmd.split_wr) begin
            wr_en   = 1'b1;
            wr_addr = pick_nxt[IW-1:0];
            wr_data = '0;
            wr_data.start = pick_rec_reg.start + need_reg[ADDR_W-1:0];
            wr_data.len   = rem;
        end else if (cmd.grant_wr) begin
            wr_en         = 1'b1;
            wr_addr       = pick_idx_reg;
            wr_data       = pick_rec_reg;
            wr_data.len   = split_reg ? need_reg : pick_rec_reg.len;
            wr_data.busy  = 1'b1;
            wr_data.order = next_order_reg;
            wr_data.stamp = now_reg;
        end else if (cmd.evict_wr) begin
            wr_en        = 1'b1;
            wr_addr      = vic_idx_reg;
            wr_data      = vic_rec_reg;
            wr_data.busy = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_q_reg    <= mem[rd_addr];
        rd_dflt_reg <= (rd_addr == '0) && !e0_ok_reg;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_size_reg   <= MEM_SIZE_RST;
            min_size_reg   <= MIN_SIZE_RST;
            fit_mode_reg   <= 1'b0;
            vic_mode_reg   <= 1'b0;
            freq_reg       <= FREQ_RST;
            cnt_reg        <= CW'(1);
            e0_ok_reg      <= 1'b0;
            next_order_reg <= '0;
            fail_reg       <= '0;
            tick_reg       <= '0;
            idx_reg        <= '0;
            sh_idx_reg     <= '0;
            w_reg          <= '0;
            chk_v_reg      <= 1'b0;
            pend_v_reg     <= 1'b0;
            pick_v_reg     <= 1'b0;
            vic_v_reg      <= 1'b0;
            split_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MEM_SIZE: begin
                        mem_size_reg   <= cfg_clamped;
                        cnt_reg        <= CW'(1);
                        e0_ok_reg      <= 1'b0;
                        next_order_reg <= '0;
                        fail_reg       <= '0;
                    end
                    REG_MIN_PART:     min_size_reg <= cfg_wdata;
                    REG_FIT_MODE:     fit_mode_reg <= cfg_wdata[0];
                    REG_VICTIM_MODE:  vic_mode_reg <= cfg_wdata[0];
                    REG_COMPACT_FREQ: freq_reg     <= cfg_wdata[FAIL_W-1:0];
                    default: ;
                endcase
            end
            if (wr_en && wr_addr == '0)
                e0_ok_reg <= 1'b1;
            if (cmd.accept) begin
                tick_reg   <= tick_reg + STAMP_W'(1);
                idx_reg    <= '0;
                chk_v_reg  <= 1'b0;
                pick_v_reg <= 1'b0;
                vic_v_reg  <= 1'b0;
            end
            if (cmd.scan || cmd.compact) begin
                if (idx_reg < cnt_reg) begin
                    idx_reg   <= idx_reg + CW'(1);
                    chk_v_reg <= 1'b1;
                end else begin
                    chk_v_reg <= 1'b0;
                end
            end
            if (cmd.scan && chk_v_reg) begin
                if (fit_hit)
                    pick_v_reg <= 1'b1;
                if (vic_hit)
                    vic_v_reg <= 1'b1;
            end
            if (cmd.decide) begin
                split_reg  <= stat.split;
                sh_idx_reg <= cnt_reg;
                idx_reg    <= '0;
                chk_v_reg  <= 1'b0;
                pend_v_reg <= 1'b0;
                w_reg      <= '0;
                if (action_reg == ACT_ALLOC && !stat.too_big && !pick_v_reg)
                    fail_reg <= stat.fail_compact ? '0 : fail_inc;
            end
            if (cmd.shift) begin
                pend_v_reg <= sh_go;
                if (sh_go)
                    sh_idx_reg <= sh_idx_reg - CW'(1);
            end
            if (cmd.compact && chk_v_reg && ent.busy)
                w_reg <= w_reg + CW'(1);
            if (cmd.tail_wr)
                cnt_reg <= tail_ok ? w_reg + CW'(1) : w_reg;
            if (cmd.split_wr)
                cnt_reg <= cnt_reg + CW'(1);
            if (cmd.grant_wr)
                next_order_reg <= next_order_reg + ORD_W'(1);
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        chk_idx_reg   <= rd_addr;
        pend_addr_reg <= sh_idx_reg[IW-1:0];
        if (cmd.accept) begin
            action_reg      <= in_action;
            req_reg         <= in_req;
            need_reg        <= need_new;
            now_reg         <= tick_reg;
            res_status      <= STS_OK;
            res_alloc_start <= '0;
            res_alloc_order <= '0;
            res_ev_valid    <= 1'b0;
            res_ev_start    <= '0;
            res_compacted   <= 1'b0;
        end
        if (cmd.scan && chk_v_reg) begin
            if (fit_hit) begin
                pick_rec_reg <= ent;
                pick_idx_reg <= chk_idx_reg;
            end
            if (vic_hit) begin
                vic_rec_reg <= ent;
                vic_idx_reg <= chk_idx_reg;
                vic_age_reg <= age;
            end
        end
        if (cmd.decide) begin
            off_reg <= '0;
            if (action_reg == ACT_ALLOC && stat.too_big)
                res_status <= STS_TOO_BIG;
            else if (action_reg == ACT_ALLOC && !pick_v_reg)
                res_status <= STS_NO_SPACE;
            else if (action_reg == ACT_EVICT && !vic_v_reg)
                res_status <= STS_NO_BUSY;
        end
        if (cmd.compact && chk_v_reg && ent.busy)
            off_reg <= off_reg + ent.len;
        if (cmd.tail_wr)
            res_compacted <= 1'b1;
        if (cmd.grant_wr) begin
            res_alloc_start <= pick_rec_reg.start;
            res_alloc_order <= next_order_reg;
        end
        if (cmd.evict_wr) begin
            res_ev_valid <= 1'b1;
            res_ev_start <= vic_rec_reg.start;
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != '0 && cnt_reg <= MAX_CNT)
        else $error("partition count out of range");

    a_split_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.split_wr |-> cnt_reg < MAX_CNT)
        else $error("split into a full table");

    a_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> tick_reg == $past(tick_reg) + STAMP_W'(1))
        else $error("tick did not advance on accepted beat");

endmodule

FILE: hdl/dpa_ctrl.sv
// ----------------------------------------------------------------------------
// dpa_ctrl
// Sequencer: scan, decide, then shift/split/grant (or grant alone), evict or compact.
// ----------------------------------------------------------------------------
module dpa_ctrl
    import dpa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      out_free,
    output logic      out_load,
    input  dpa_stat_t stat,
    output dpa_cmd_t  cmd
);

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b0000000001,
        ST_SCAN    = 10'b0000000010,
        ST_DECIDE  = 10'b0000000100,
        ST_SHIFT   = 10'b0000001000,
        ST_SPLIT   = 10'b0000010000,
        ST_GRANT   = 10'b0000100000,
        ST_EVICT   = 10'b0001000000,
        ST_COMPACT = 10'b0010000000,
        ST_TAIL    = 10'b0100000000,
        ST_DONE    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.loop_done)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                case (stat.action)
                    ACT_ALLOC: begin
                        if (stat.too_big)
                            state_next = ST_DONE;
                        else if (stat.pick_v)
                            state_next = stat.split ? ST_SHIFT : ST_GRANT;
                        else if (stat.fail_compact)
                            state_next = ST_COMPACT;
                        else
                            state_next = stat.vic_v ? ST_EVICT : ST_DONE;
                    end
                    ACT_EVICT:   state_next = stat.vic_v ? ST_EVICT : ST_DONE;
                    ACT_COMPACT: state_next = ST_COMPACT;
                    default:     state_next = ST_DONE;
                endcase
            end
            ST_SHIFT: begin
                cmd.shift = 1'b1;
                if (stat.shift_done)
                    state_next = ST_SPLIT;
            end
            ST_SPLIT: begin
                cmd.split_wr = 1'b1;
                state_next   = ST_GRANT;
            end
            ST_GRANT: begin
                cmd.grant_wr = 1'b1;
                state_next   = ST_DONE;
            end
            ST_EVICT: begin
                cmd.evict_wr = 1'b1;
                state_next   = ST_DONE;
            end
            ST_COMPACT: begin
                cmd.compact = 1'b1;
                if (stat.loop_done)
                    state_next = ST_TAIL;
            end
            ST_TAIL: begin
                cmd.tail_wr = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: tb/tb_dynamic_partition_allocator.sv
// ----------------------------------------------------------------------------
// tb_dynamic_partition_allocator
// Self-checking bench for the partition allocator: a directed table of
// requests then constrained-free random traffic over several register
// settings, each result beat compared with a behavioural table model.
// ----------------------------------------------------------------------------
module tb_dynamic_partition_allocator;
    timeunit 1ns;
    timeprecision 1ps;
    import dpa_pkg::*;

    localparam int NPARTS = 64;

    typedef struct packed {
        logic        compacted;
        logic [15:0] evicted_start;
        logic        evicted_valid;
        logic [15:0] alloc_order;
        logic [15:0] alloc_start;
        logic [1:0]  status;
    } alloc_res_t;

    typedef struct {
        logic [1:0]  action;
        logic [16:0] req;
        logic        known;
        alloc_res_t  res;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [55:0] m_tdata;

    dynamic_partition_allocator uut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mirror of the partition table
    logic [16:0] m_mem, m_min, m_freq;
    logic        m_fit, m_vic;
    logic [15:0] t_start [NPARTS];
    logic [16:0] t_len [NPARTS];
    logic        t_busy [NPARTS];
    logic [15:0] t_order [NPARTS];
    logic [31:0] t_stamp [NPARTS];
    int          t_count;
    logic [15:0] nxt_order;
    logic [7:0]  fails;
    logic [31:0] ticks;

    alloc_res_t expected_q[$];
    int errors = 0;
    bit quiet_rx = 0;
    bit quiet_tx = 0;

    function automatic void table_init();
        t_count = 1;
        t_start[0] = '0;
        t_len[0] = m_mem;
        t_busy[0] = 0;
        nxt_order = '0;
        fails = '0;
    endfunction

    function automatic void table_compact();
        int w;
        int off;
        w = 0;
        off = 0;
        for (int r = 0; r < t_count; r++) begin
            if (t_busy[r]) begin
                t_len[w] = t_len[r];
                t_order[w] = t_order[r];
                t_stamp[w] = t_stamp[r];
                t_busy[w] = 1;
                t_start[w] = 16'(off);
                off += t_len[r];
                w++;
            end
        end
        if (off < m_mem && w < NPARTS) begin
            t_busy[w] = 0;
            t_start[w] = 16'(off);
            t_len[w] = 17'(m_mem - off);
            t_order[w] = '0;
            t_stamp[w] = '0;
            w++;
        end
        t_count = w;
    endfunction

    function automatic int pick_victim();
        int pick;
        logic [31:0] age, best;
        pick = -1;
        best = '0;
        for (int i = 0; i < t_count; i++) begin
            if (t_busy[i]) begin
                age = m_vic ? ticks - t_stamp[i] : 32'(16'(nxt_order - t_order[i]));
                if (pick < 0 || age > best) begin
                    pick = i;
                    best = age;
                end
            end
        end
        if (pick >= 0) t_busy[pick] = 0;
        return pick;
    endfunction

    function automatic alloc_res_t predict_alloc(logic [1:0] act, logic [16:0] req);
        alloc_res_t r;
        logic [31:0] now;
        logic [16:0] need;
        int pick;
        int v;
        r = '0;
        now = ticks;
        ticks++;
        if (act == ACT_ALLOC) begin
            if (req > m_mem) begin
                r.status = STS_TOO_BIG;
            end else begin
                need = (m_min == 0) ? 17'd1 : m_min;
                if (req > need) need = req;
                pick = -1;
                for (int i = 0; i < t_count; i++) begin
                    if (!t_busy[i] && t_len[i] >= need) begin
                        if (pick < 0 || (m_fit && t_len[i] < t_len[pick])) pick = i;
                        if (!m_fit) break;
                    end
                end
                if (pick >= 0) begin
                    if (t_len[pick] > need && t_count < NPARTS) begin
                        for (int i = t_count; i > pick + 1; i--) begin
                            t_start[i] = t_start[i-1];
                            t_len[i] = t_len[i-1];
                            t_busy[i] = t_busy[i-1];
                            t_order[i] = t_order[i-1];
                            t_stamp[i] = t_stamp[i-1];
                        end
                        t_start[pick+1] = t_start[pick] + 16'(need);
                        t_len[pick+1] = t_len[pick] - need;
                        t_busy[pick+1] = 0;
                        t_order[pick+1] = '0;
                        t_stamp[pick+1] = '0;
                        t_len[pick] = need;
                        t_count++;
                    end
                    t_busy[pick] = 1;
                    t_order[pick] = nxt_order;
                    t_stamp[pick] = now;
                    r.alloc_start = t_start[pick];
                    r.alloc_order = nxt_order;
                    nxt_order++;
                end else begin
                    r.status = STS_NO_SPACE;
                    if (fails != 8'hFF) fails++;
                    if (17'(fails) >= m_freq) begin
                        table_compact();
                        fails = '0;
                        r.compacted = 1;
                    end else begin
                        v = pick_victim();
                        if (v >= 0) begin
                            r.evicted_valid = 1;
                            r.evicted_start = t_start[v];
                        end
                    end
                end
            end
        end else if (act == ACT_EVICT) begin
            v = pick_victim();
            if (v >= 0) begin
                r.evicted_valid = 1;
                r.evicted_start = t_start[v];
            end else begin
                r.status = STS_NO_BUSY;
            end
        end else if (act == ACT_COMPACT) begin
            table_compact();
            r.compacted = 1;
        end
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [16:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_MEM_SIZE: begin
                m_mem = (val == 0) ? 17'd1 : (val > MEM_SIZE_MAX ? MEM_SIZE_MAX : val);
                table_init();
            end
            REG_MIN_PART:     m_min = val;
            REG_FIT_MODE:     m_fit = val[0];
            REG_VICTIM_MODE:  m_vic = val[0];
            REG_COMPACT_FREQ: m_freq = 17'(val[7:0]);
            default: ;
        endcase
    endtask

    // drop valid, drain results, then allow the block to settle before touching registers
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic send_beat(logic [1:0] act, logic [16:0] req, bit known, alloc_res_t want);
        alloc_res_t p;
        int gap;
        if (!quiet_tx && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {7'd0, req};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        p = predict_alloc(act, req);
        if (known && p != want) begin
            $error("table row disagrees with model: row %h model %h", want, p);
            errors++;
        end
        expected_q.push_back(p);
    endtask

    // receiver with random stall bursts
    initial begin
        int stall;
        alloc_res_t got, want;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got = m_tdata[51:0];
                if (expected_q.size() == 0) begin
                    $error("result beat with nothing expected: %h", got);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status) begin
                        $error("status exp %0d got %0d", want.status, got.status); errors++;
                    end
                    if (got.alloc_start !== want.alloc_start) begin
                        $error("alloc_start exp %0d got %0d", want.alloc_start, got.alloc_start);
                        errors++;
                    end
                    if (got.alloc_order !== want.alloc_order) begin
                        $error("alloc_order exp %0d got %0d", want.alloc_order, got.alloc_order);
                        errors++;
                    end
                    if (got.evicted_valid !== want.evicted_valid) begin
                        $error("evicted_valid exp %0d got %0d", want.evicted_valid,
                               got.evicted_valid);
                        errors++;
                    end
                    if (got.evicted_start !== want.evicted_start) begin
                        $error("evicted_start exp %0d got %0d", want.evicted_start,
                               got.evicted_start);
                        errors++;
                    end
                    if (got.compacted !== want.compacted) begin
                        $error("compacted exp %0d got %0d", want.compacted, got.compacted);
                        errors++;
                    end
                end
            end
            if (!quiet_rx && !aresetn == 0 && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 13);
                m_tready <= 1'b0;
                repeat (stall - 1) @(posedge aclk);
                @(posedge aclk);
                // the beat after a stall is checked on the next loop pass
                m_tready <= 1'b1;
            end else begin
                m_tready <= aresetn;
            end
        end
    end

    function automatic alloc_res_t mk(logic [1:0] s, logic [15:0] a, logic [15:0] o,
                                      logic ev, logic [15:0] es, logic c);
        alloc_res_t r;
        r.status = s; r.alloc_start = a; r.alloc_order = o;
        r.evicted_valid = ev; r.evicted_start = es; r.compacted = c;
        return r;
    endfunction

    function automatic logic [16:0] rand_size();
        case ($urandom_range(0, 9))
            0:       return 17'($urandom_range(0, 65536));
            1:       return 17'($urandom_range(0, 3));
            2, 3:    return 17'($urandom_range(0, 64));
            default: return 17'($urandom_range(1, 700));
        endcase
    endfunction

    initial begin
        stim_row_t dir[$];
        stim_row_t row;
        dir = '{
            '{ACT_EVICT,   17'd0,     1, mk(STS_NO_BUSY, 0, 0, 0, 0, 0)},
            '{ACT_ALLOC,   17'd4097,  1, mk(STS_TOO_BIG, 0, 0, 0, 0, 0)},
            '{ACT_ALLOC,   17'd0,     1, mk(STS_OK, 0, 0, 0, 0, 0)},
            '{ACT_ALLOC,   17'd1,     1, mk(STS_OK, 64, 1, 0, 0, 0)},
            '{ACT_ALLOC,   17'd100,   1, mk(STS_OK, 128, 2, 0, 0, 0)},
            '{ACT_ALLOC,   17'd4096,  1, mk(STS_NO_SPACE, 0, 0, 1, 0, 0)},
            '{ACT_ALLOC,   17'd4096,  1, mk(STS_NO_SPACE, 0, 0, 0, 0, 1)},
            '{2'd3,        17'h1FFFF, 1, mk(STS_OK, 0, 0, 0, 0, 0)},
            '{ACT_COMPACT, 17'd0,     1, mk(STS_OK, 0, 0, 0, 0, 1)},
            '{ACT_EVICT,   17'd0,     0, '0},
            '{ACT_EVICT,   17'd0,     0, '0},
            '{ACT_EVICT,   17'd0,     1, mk(STS_NO_BUSY, 0, 0, 0, 0, 0)},
            '{ACT_ALLOC,   17'd65536, 1, mk(STS_TOO_BIG, 0, 0, 0, 0, 0)},
            '{ACT_ALLOC,   17'd4096,  0, '0},
            '{ACT_ALLOC,   17'd1,     0, '0},
            '{ACT_COMPACT, 17'd0,     0, '0}
        };
        m_mem = MEM_SIZE_RST; m_min = MIN_SIZE_RST; m_freq = 17'(FREQ_RST);
        m_fit = 0; m_vic = 0; ticks = '0;
        table_init();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir[i]) send_beat(dir[i].action, dir[i].req, dir[i].known, dir[i].res);
        wait_idle();

        // extremes of the registers, then random settings
        write_reg(REG_MEM_SIZE, 17'd65536);
        write_reg(REG_MIN_PART, 17'd0);
        write_reg(REG_FIT_MODE, 17'd1);
        write_reg(REG_VICTIM_MODE, 17'd1);
        write_reg(REG_COMPACT_FREQ, 17'd255);
        for (int n = 0; n < 80; n++) send_beat(2'($urandom_range(0, 3)), rand_size(), 0, '0);
        wait_idle();
        write_reg(REG_MEM_SIZE, 17'd0);
        write_reg(REG_MIN_PART, 17'h1FFFF);
        write_reg(REG_COMPACT_FREQ, 17'd0);
        for (int n = 0; n < 20; n++) send_beat(2'($urandom_range(0, 3)), rand_size(), 0, '0);
        wait_idle();
        write_reg(REG_MEM_SIZE, 17'h1FFFF);
        write_reg(REG_MIN_PART, 17'd65536);
        for (int n = 0; n < 20; n++) send_beat(2'($urandom_range(0, 3)), rand_size(), 0, '0);

        for (int ph = 0; ph < 12; ph++) begin
            wait_idle();
            if (ph == 11) begin
                quiet_tx = 1;
                quiet_rx = 1;
            end
            write_reg(REG_MEM_SIZE, 17'($urandom_range(1, 8192)));
            write_reg(REG_MIN_PART, 17'($urandom_range(0, 80)));
            write_reg(REG_FIT_MODE, 17'($urandom_range(0, 1)));
            write_reg(REG_VICTIM_MODE, 17'($urandom_range(0, 1)));
            write_reg(REG_COMPACT_FREQ, 17'($urandom_range(0, 6)));
            for (int n = 0; n < 120; n++) begin
                case ($urandom_range(0, 19))
                    0, 1, 2: row.action = ACT_EVICT;
                    3:       row.action = ACT_COMPACT;
                    4:       row.action = 2'd3;
                    default: row.action = ACT_ALLOC;
                endcase
                send_beat(row.action, rand_size(), 0, '0);
            end
        end

        wait_idle();
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/dpa_pkg.sv
hdl/dpa_datapath.sv
hdl/dpa_ctrl.sv
hdl/dynamic_partition_allocator.sv
tb/tb_dynamic_partition_allocator.sv
